[rtl/assert_macros.svh]
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/lsw_pkg.sv]
`timescale 1ns / 1ps

package lsw_pkg;

    // Width of every node and length field on the channels.
    localparam int FIELD_W = 9;

    // One edge of the graph: a node and its successor, both 1-based.
    typedef struct packed {
        logic [FIELD_W-1:0] source_node;
        logic [FIELD_W-1:0] target_node;
        logic               last;
    } edge_t;

    // The answer of one job.
    typedef struct packed {
        logic [FIELD_W-1:0] start_node;
        logic [FIELD_W-1:0] chain_length;
    } result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FINISH
    } lsw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic search_start;
        logic scan_next;
        logic walk_start;
        logic walk_step;
        logic walk_finish;
        logic out_load;
    } lsw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic scan_end;
        logic pointed;
        logic vis_hit;
        logic out_free;
    } lsw_status_t;

endpackage

[rtl/lsw_stream_if.sv]
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transaction.
interface lsw_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/lsw_controller.sv]
`timescale 1ns / 1ps

module lsw_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                edge_valid,
    input  logic                edge_last,
    input  lsw_pkg::lsw_status_t status,
    output lsw_pkg::lsw_cmd_t    cmd,
    output logic                edge_ready
);
    import lsw_pkg::*;

    lsw_state_t state_reg;
    lsw_state_t state_next;

    // State register; reset starts with a sweep that clears the mark memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        edge_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                edge_ready = 1'b1;
                if (edge_valid)
                begin
                    cmd.load = 1'b1;
                    if (edge_last)
                    begin
                        cmd.search_start = 1'b1;
                        state_next       = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (status.pointed)
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK:
            begin
                if (status.vis_hit)
                begin
                    cmd.walk_finish = 1'b1;
                    state_next      = ST_SCAN_RD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/lsw_datapath.sv]
`timescale 1ns / 1ps

module lsw_datapath #(
    parameter int MAX_NODES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsw_pkg::edge_t       edge_data,
    input  lsw_pkg::lsw_cmd_t    cmd,
    input  logic                 result_ready,
    output lsw_pkg::lsw_status_t status,
    output logic                 result_valid,
    output lsw_pkg::result_t     result_data
);
    import lsw_pkg::*;

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    // Successor table, pointed-to marks and per-walk visit tags.
    logic [NW-1:0] succ_mem    [MAX_NODES];
    logic          pointed_mem [MAX_NODES];
    logic [CW-1:0] vis_mem     [MAX_NODES];

    logic [NW-1:0] succ_rd;
    logic          pointed_rd;
    logic [CW-1:0] vis_rd;

    logic [CW-1:0] node_count_reg, node_count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [NW-1:0] walk_node_reg, walk_node_next;
    logic [CW-1:0] walk_count_reg, walk_count_next;
    logic [NW-1:0] best_node_reg, best_node_next;
    logic [CW-1:0] best_len_reg, best_len_next;
    logic [NW-1:0] clear_idx_reg, clear_idx_next;
    logic          out_valid_reg, out_valid_next;
    result_t       result_reg;

    logic          src_ok;
    logic          dst_ok;
    logic          edge_ok;
    logic [NW-1:0] src_idx;
    logic [NW-1:0] dst_idx;
    logic [CW-1:0] walk_tag;
    logic          clear_done;

    // Edge decode: an out-of-range node writes and marks nothing.
    assign src_ok  = (edge_data.source_node != '0)
                     && (32'(edge_data.source_node) <= MAX_NODES);
    assign dst_ok  = (edge_data.target_node != '0)
                     && (32'(edge_data.target_node) <= MAX_NODES);
    assign edge_ok = src_ok && dst_ok;
    assign src_idx = NW'(32'(edge_data.source_node) - 32'd1);
    assign dst_idx = NW'(32'(edge_data.target_node) - 32'd1);

    // Each walk tags the nodes it visits with its start index plus one.
    assign walk_tag   = scan_idx_reg + CW'(1);
    assign clear_done = (clear_idx_reg == NW'(MAX_NODES - 1));

    // Successor memory: written by edges, read at the walk node.
    always_ff @(posedge clk)
    begin
        if (cmd.load && edge_ok)
        begin
            succ_mem[src_idx] <= dst_idx;
        end
        succ_rd <= succ_mem[walk_node_reg];
    end

    // Pointed-to memory: marked by edges, cleared by the sweep, read by the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            pointed_mem[clear_idx_reg] <= 1'b0;
        end
        else if (cmd.load && edge_ok)
        begin
            pointed_mem[dst_idx] <= 1'b1;
        end
        pointed_rd <= pointed_mem[scan_idx_reg[NW-1:0]];
    end

    // Visit-tag memory: tagged by walk steps, cleared by the sweep.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            vis_mem[clear_idx_reg] <= '0;
        end
        else if (cmd.walk_step)
        begin
            vis_mem[walk_node_reg] <= walk_tag;
        end
        vis_rd <= vis_mem[walk_node_reg];
    end

    // Next values of the search registers.
    always_comb
    begin
        node_count_next = node_count_reg;
        scan_idx_next   = scan_idx_reg;
        walk_node_next  = walk_node_reg;
        walk_count_next = walk_count_reg;
        best_node_next  = best_node_reg;
        best_len_next   = best_len_reg;
        clear_idx_next  = clear_idx_reg;
        out_valid_next  = out_valid_reg;

        // Edge count saturates at the table depth.
        if (cmd.load && (node_count_reg != CW'(MAX_NODES)))
        begin
            node_count_next = node_count_reg + CW'(1);
        end
        if (cmd.out_load)
        begin
            node_count_next = '0;
        end

        if (cmd.clear_step)
        begin
            clear_idx_next = clear_done ? '0 : clear_idx_reg + NW'(1);
        end

        if (cmd.search_start)
        begin
            scan_idx_next  = '0;
            best_node_next = '0;
            best_len_next  = '0;
        end

        if (cmd.scan_next)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
        end

        if (cmd.walk_start)
        begin
            walk_node_next  = scan_idx_reg[NW-1:0];
            walk_count_next = '0;
        end

        if (cmd.walk_step)
        begin
            walk_node_next  = succ_rd;
            walk_count_next = walk_count_reg + CW'(1);
        end

        // A strictly longer walk replaces the best, so the earliest start wins ties.
        if (cmd.walk_finish)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
            if (walk_count_reg > best_len_reg)
            begin
                best_node_next = scan_idx_reg[NW-1:0];
                best_len_next  = walk_count_reg;
            end
        end

        // Result register: loaded at the end of a search, freed by a transaction.
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            scan_idx_reg   <= '0;
            walk_node_reg  <= '0;
            walk_count_reg <= '0;
            best_node_reg  <= '0;
            best_len_reg   <= '0;
            clear_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            scan_idx_reg   <= scan_idx_next;
            walk_node_reg  <= walk_node_next;
            walk_count_reg <= walk_count_next;
            best_node_reg  <= best_node_next;
            best_len_reg   <= best_len_next;
            clear_idx_reg  <= clear_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.start_node   <= FIELD_W'(32'(best_node_reg) + 32'd1);
            result_reg.chain_length <= FIELD_W'(best_len_reg);
        end
    end

    assign status.clear_done = clear_done;
    assign status.scan_end   = (scan_idx_reg == node_count_reg);
    assign status.pointed    = pointed_rd;
    assign status.vis_hit    = (vis_rd == walk_tag);
    assign status.out_free   = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result_data  = result_reg;

endmodule

[rtl/longest_source_walk_finder.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Loads a functional graph one edge per cycle, then, after the edge marked last, walks from
// every node that no edge points to and reports the start with the longest walk and its
// length. Edges are taken one per cycle. After the last edge the search reads and then checks
// the pointed-to mark of each node below the edge count, reads and then checks each node a
// walk visits, and reads and checks once more for each walk to find the node that repeats, since
// each walk step reads the successor and visit memories through one registered port. A last
// scan read ends the scan, and the result register is loaded when it is free or its result is being taken.
// A sweep of every entry then clears the pointed-to and visit memories; the same sweep
// runs after reset, and no edge is taken during search or sweep. The result sits in an output
// register, so edges of the next job load while it waits to be taken.
module longest_source_walk_finder #(
    parameter int MAX_NODES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    lsw_stream_if.sink   edge_in,
    lsw_stream_if.source result_out
);
    import lsw_pkg::*;

    lsw_cmd_t    cmd;
    lsw_status_t status;
    edge_t       edge_data;
    result_t     result_data;

    assign edge_data       = edge_in.data;
    assign result_out.data = result_data;

    // Sequencer for load, scan, walk and clear.
    lsw_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (edge_in.valid),
        .edge_last  (edge_data.last),
        .status     (status),
        .cmd        (cmd),
        .edge_ready (edge_in.ready)
    );

    // Memories, counters and the result register.
    lsw_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_data    (edge_data),
        .cmd          (cmd),
        .result_ready (result_out.ready),
        .status       (status),
        .result_valid (result_out.valid),
        .result_data  (result_data)
    );

    // A result is never loaded while edges are being taken.
    `ASSERT_SAME_CYCLE(a_no_load_while_ready, clk, rst_n, edge_in.ready, !cmd.out_load)

    // A pending result is never overwritten.
    `ASSERT_SAME_CYCLE(a_load_only_when_free, clk, rst_n, cmd.out_load,
                       !result_out.valid || result_out.ready)

    // Accepting the last edge starts the search and stops the input.
    `ASSERT_NEXT_CYCLE(a_last_starts_search, clk, rst_n,
                       edge_in.valid && edge_in.ready && edge_data.last, !edge_in.ready)

    // Walk steps never overlap input transactions.
    `ASSERT_NEXT_CYCLE(a_walk_blocks_input, clk, rst_n, cmd.walk_step, !edge_in.ready)

endmodule
